FILE: rtl/core/sas_pkg.sv
package sas_pkg;

  localparam int unsigned ELEM_W = 64;

  // Key interpretation codes for element_kind
  localparam logic KIND_INT    = 1'b0;
  localparam logic KIND_DOUBLE = 1'b1;

  localparam logic [31:0]       INT_SIGN = 32'h8000_0000;
  localparam logic [ELEM_W-1:0] DBL_SIGN = 64'h8000_0000_0000_0000;
  localparam logic [10:0]       EXP_ONES = 11'h7FF;

  typedef struct packed {
    logic [ELEM_W-1:0] element_bits;
    logic              final_element;
  } sas_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] sorted_bits;
    logic              last_result;
    logic              overflowed;
  } sas_out_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic adv;
    logic element_kind;
  } sas_ctrl_t;

  // True when a must move right of b; a NaN on either side never swaps,
  // and the two zeros compare equal.
  function automatic logic key_greater(logic kind, logic [ELEM_W-1:0] a,
                                       logic [ELEM_W-1:0] b);
    logic [31:0]       ia;
    logic [31:0]       ib;
    logic [ELEM_W-1:0] ka;
    logic [ELEM_W-1:0] kb;
    logic              nan_a;
    logic              nan_b;
    logic              zeros;
    logic              r;
    ia    = a[31:0] ^ INT_SIGN;
    ib    = b[31:0] ^ INT_SIGN;
    nan_a = (a[62:52] == EXP_ONES) && (a[51:0] != 52'd0);
    nan_b = (b[62:52] == EXP_ONES) && (b[51:0] != 52'd0);
    zeros = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    ka    = a[63] ? ~a : (a ^ DBL_SIGN);
    kb    = b[63] ? ~b : (b ^ DBL_SIGN);
    if (kind == KIND_DOUBLE) begin
      r = !nan_a && !nan_b && !zeros && (ka > kb);
    end else begin
      r = ia > ib;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sas_ram.sv
module sas_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sas_cell.sv
module sas_cell #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX      = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sas_pkg::sas_ctrl_t            ctrl_i,
  input  logic [$clog2(CAPACITY+1)-1:0] n_i,
  input  logic                          in_v_i,
  input  logic [sas_pkg::ELEM_W-1:0]    in_d_i,
  input  logic [$clog2(CAPACITY)-1:0]   in_p_i,
  output logic                          out_v_o,
  output logic [sas_pkg::ELEM_W-1:0]    out_d_o,
  output logic [$clog2(CAPACITY)-1:0]   out_p_o
);

  localparam int unsigned PW   = $clog2(CAPACITY);
  localparam int unsigned CNTW = $clog2(CAPACITY+1);

  logic [sas_pkg::ELEM_W-1:0] c_q, c_d;
  logic                       cv_q, cv_d;
  logic                       end_q, end_d;
  logic                       ov_q, ov_d;
  logic [sas_pkg::ELEM_W-1:0] od_q, od_d;
  logic [PW-1:0]              op_q, op_d;
  logic                       cmp_en;
  logic                       swap;

  // This pass compares only the pairs left of its settled tail
  assign cmp_en = ((CNTW+1)'(in_p_i) + (CNTW+1)'(IDX + 1)) <= (CNTW+1)'(n_i);
  assign swap   = cmp_en && sas_pkg::key_greater(ctrl_i.element_kind, c_q, in_d_i);

  // One step of a bubble pass: keep the larger, pass the other on
  always_comb begin
    c_d   = c_q;
    cv_d  = cv_q;
    end_d = end_q;
    ov_d  = 1'b0;
    od_d  = od_q;
    op_d  = op_q;
    if (in_v_i) begin
      end_d = (CNTW'(in_p_i) == (n_i - CNTW'(1)));
      cv_d  = 1'b1;
      if (cv_q) begin
        ov_d = 1'b1;
        od_d = swap ? in_d_i : c_q;
        c_d  = swap ? c_q : in_d_i;
        op_d = in_p_i - PW'(1);
      end else begin
        c_d = in_d_i;
      end
    end else if (cv_q && end_q) begin
      // flush the carried element after the last one went by
      ov_d  = 1'b1;
      od_d  = c_q;
      op_d  = PW'(n_i - CNTW'(1));
      cv_d  = 1'b0;
      end_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q  <= 1'b0;
      end_q <= 1'b0;
      ov_q  <= 1'b0;
    end else if (ctrl_i.adv) begin
      cv_q  <= cv_d;
      end_q <= end_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      c_q  <= c_d;
      od_q <= od_d;
      op_q <= op_d;
    end
  end

  assign out_v_o = ov_q;
  assign out_d_o = od_q;
  assign out_p_o = op_q;

endmodule

FILE: rtl/core/stable_ascending_sorter.sv
// Stable ascending sorter.
// Input channel (in_valid_i / in_stall_o, payload in_data_i): one element per
// transfer, final_element marks the last one of a set. Elements beyond
// CAPACITY are dropped and overflowed is set on every result of that set.
// Loading takes one element per cycle. After the final transfer the set is
// read from the store and streamed through CAPACITY-1 compare cells, one
// bubble pass per cell, and then through the output register; the results
// follow one per cycle while the output is not stalled.
// Output channel (out_valid_o / out_stall_i, payload out_data_o): one result
// per stored element, last_result on the final one. No new set is taken
// until that final result has been transferred.
// A stall while a result is valid freezes the whole cell chain and holds the result.
// cfg_we_i / cfg_data_i write element_kind (0 signed 32-bit, 1 double); the
// value present at the final transfer governs the sort.
// Reset empties the store and the chain and clears element_kind.
module stable_ascending_sorter #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sas_pkg::sas_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sas_pkg::sas_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i
);

  localparam int unsigned PW    = $clog2(CAPACITY);
  localparam int unsigned CNTW  = $clog2(CAPACITY+1);
  localparam int unsigned NCELL = CAPACITY - 1;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_SORT = 1'b1;

  logic                 state_q, state_d;
  logic                 kind_q;
  logic                 sort_kind_q, sort_kind_d;
  logic [CNTW-1:0]      count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic                 set_ovf_q, set_ovf_d;
  logic [CNTW-1:0]      n_q, n_d;
  logic [CNTW-1:0]      rd_idx_q, rd_idx_d;
  logic                 src_v_q;
  logic [PW-1:0]        src_p_q;
  logic                 out_valid_q;
  sas_pkg::sas_out_t    out_data_q;

  logic                 in_xfer;
  logic                 out_xfer;
  logic                 store_ok;
  logic                 adv;
  logic                 issue;
  logic [sas_pkg::ELEM_W-1:0] rd_data;
  sas_pkg::sas_ctrl_t   ctrl;

  logic                       chain_v [NCELL+1];
  logic [sas_pkg::ELEM_W-1:0] chain_d [NCELL+1];
  logic [PW-1:0]              chain_p [NCELL+1];

  // Handshake and advance control
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign store_ok   = count_q < CNTW'(CAPACITY);
  assign adv        = !out_valid_q || !out_stall_i;
  assign issue      = (state_q == ST_SORT) && (rd_idx_q < n_q);

  assign ctrl.adv          = adv;
  assign ctrl.element_kind = sort_kind_q;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= sas_pkg::KIND_INT;
    end else if (cfg_we_i) begin
      kind_q <= cfg_data_i;
    end
  end

  // Load and sort sequencing
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    set_ovf_d   = set_ovf_q;
    n_d         = n_q;
    sort_kind_d = sort_kind_q;
    rd_idx_d    = rd_idx_q;
    case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (in_data_i.final_element) begin
            state_d     = ST_SORT;
            n_d         = count_q + CNTW'(store_ok);
            set_ovf_d   = ovf_q || !store_ok;
            sort_kind_d = kind_q;
            count_d     = '0;
            ovf_d       = 1'b0;
            rd_idx_d    = '0;
          end else begin
            count_d = count_q + CNTW'(store_ok);
            ovf_d   = ovf_q || !store_ok;
          end
        end
      end
      ST_SORT: begin
        if (adv && issue) begin
          rd_idx_d = rd_idx_q + CNTW'(1);
        end
        if (out_xfer && out_data_q.last_result) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      set_ovf_q   <= 1'b0;
      n_q         <= '0;
      sort_kind_q <= sas_pkg::KIND_INT;
      rd_idx_q    <= '0;
      src_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      set_ovf_q   <= set_ovf_d;
      n_q         <= n_d;
      sort_kind_q <= sort_kind_d;
      rd_idx_q    <= rd_idx_d;
      if (adv) begin
        src_v_q     <= issue;
        out_valid_q <= chain_v[NCELL];
      end
    end
  end

  // Payload registers: source position and output result
  always_ff @(posedge clk_i) begin
    if (adv) begin
      src_p_q                <= rd_idx_q[PW-1:0];
      out_data_q.sorted_bits <= chain_d[NCELL];
      out_data_q.last_result <= (chain_p[NCELL] == PW'(n_q - CNTW'(1)));
      out_data_q.overflowed  <= set_ovf_q;
    end
  end

  // Element store
  sas_ram #(
    .WIDTH (sas_pkg::ELEM_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_xfer && store_ok),
    .waddr_i (count_q[PW-1:0]),
    .wdata_i (in_data_i.element_bits),
    .re_i    (adv && issue),
    .raddr_i (rd_idx_q[PW-1:0]),
    .rdata_o (rd_data)
  );

  assign chain_v[0] = src_v_q;
  assign chain_d[0] = rd_data;
  assign chain_p[0] = src_p_q;

  // One bubble pass per cell
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sas_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .n_i     (n_q),
      .in_v_i  (chain_v[k]),
      .in_d_i  (chain_d[k]),
      .in_p_i  (chain_p[k]),
      .out_v_o (chain_v[k+1]),
      .out_d_o (chain_d[k+1]),
      .out_p_o (chain_p[k+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !out_valid_q)
    else $error("result pending while loading");

  a_final_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.final_element) |=> (state_q == ST_SORT) && (n_q != '0))
    else $error("final transfer did not start a non-empty sort");

  a_chain_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_v[NCELL] |-> (CNTW'(chain_p[NCELL]) < n_q))
    else $error("chain result position beyond set size");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("element count beyond capacity");

endmodule

FILE: bench/tb_stable_ascending_sorter.sv
module tb_stable_ascending_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP       = 16;
  localparam int SETTLE    = CAP + 8;
  localparam int LIMIT     = 500000;
  localparam int PHASE_LEN = 64;

  // Ordering model of the sorter: holds the set being loaded and the
  // sorted results still owed by the block.
  class ascending_order_model;
    logic [sas_pkg::ELEM_W-1:0] held [CAP];
    int                         held_n;
    bit                         dropped;
    logic                       kind;
    sas_pkg::sas_out_t          sorted_due [$];
    int                         mismatches;
    int                         sets_done;
    int                         elements_seen;
    int                         results_seen;

    function new();
      held_n        = 0;
      dropped       = 0;
      kind          = sas_pkg::KIND_INT;
      mismatches    = 0;
      sets_done     = 0;
      elements_seen = 0;
      results_seen  = 0;
    endfunction

    function void set_kind(logic k);
      kind = k;
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction

    // True when a must sit right of b under the current key kind
    function bit ranks_above(logic [sas_pkg::ELEM_W-1:0] a, logic [sas_pkg::ELEM_W-1:0] b);
      bit a_nan;
      bit b_nan;
      if (kind == sas_pkg::KIND_INT) begin
        return $signed(a[31:0]) > $signed(b[31:0]);
      end
      a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
      b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
      if (a_nan || b_nan) begin
        return 1'b0;
      end
      if (a[62:0] == '0 && b[62:0] == '0) begin
        return 1'b0;
      end
      // sign-magnitude compare
      if (a[63] != b[63]) begin
        return !a[63];
      end
      if (!a[63]) begin
        return a[62:0] > b[62:0];
      end
      return a[62:0] < b[62:0];
    endfunction

    // Stable bubble sort of the held set, then queue one result per element
    function void bubble_set();
      logic [sas_pkg::ELEM_W-1:0] t;
      sas_pkg::sas_out_t          r;
      int                         pass;
      int                         j;
      for (pass = 0; pass < held_n; pass++) begin
        for (j = 0; j + pass + 1 < held_n; j++) begin
          if (ranks_above(held[j], held[j+1])) begin
            t         = held[j];
            held[j]   = held[j+1];
            held[j+1] = t;
          end
        end
      end
      for (j = 0; j < held_n; j++) begin
        r.sorted_bits = held[j];
        r.last_result = (j == held_n - 1);
        r.overflowed  = dropped;
        sorted_due.push_back(r);
      end
      held_n  = 0;
      dropped = 0;
      sets_done++;
    endfunction

    function void take_element(sas_pkg::sas_in_t item);
      elements_seen++;
      if (held_n < CAP) begin
        held[held_n] = item.element_bits;
        held_n++;
      end else begin
        dropped = 1;
      end
      if (item.final_element) begin
        bubble_set();
      end
    endfunction

    task report(string msg);
      if (mismatches < 40) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    task match_result(sas_pkg::sas_out_t got);
      sas_pkg::sas_out_t want;
      results_seen++;
      if (sorted_due.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got.sorted_bits));
        return;
      end
      want = sorted_due.pop_front();
      if (got.sorted_bits !== want.sorted_bits) begin
        report($sformatf("sorted_bits %h, want %h", got.sorted_bits, want.sorted_bits));
      end
      if (got.last_result !== want.last_result) begin
        report($sformatf("last_result %b, want %b (bits %h)", got.last_result,
                         want.last_result, want.sorted_bits));
      end
      if (got.overflowed !== want.overflowed) begin
        report($sformatf("overflowed %b, want %b (bits %h)", got.overflowed,
                         want.overflowed, want.sorted_bits));
      end
    endtask
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  sas_pkg::sas_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  sas_pkg::sas_out_t out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_data_i  = 1'b0;

  ascending_order_model book;
  int idle_pct    = 25;
  int stall_pct   = 80;
  int cycle_count = 0;

  stable_ascending_sorter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Check each output transfer, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      book.match_result(out_data_o);
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Offer one element, idling first at random; hold until the transfer
  task send_element(logic [sas_pkg::ELEM_W-1:0] bits, logic fin);
    sas_pkg::sas_in_t item;
    item.element_bits  = bits;
    item.final_element = fin;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    book.take_element(item);
  endtask

  // Drop valid and wait until every owed result has been transferred
  task drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task write_kind(logic k);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= k;
    @(posedge clk_i);
    book.set_kind(k);
    cfg_we_i   <= 1'b0;
  endtask

  function logic [sas_pkg::ELEM_W-1:0] int_element(logic [sas_pkg::ELEM_W-1:0] prev);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = $urandom;
    lo = $urandom;
    case ($urandom_range(0, 9))
      5: begin
        case ($urandom_range(0, 4))
          0: lo = 32'h0000_0000;
          1: lo = 32'h0000_0001;
          2: lo = 32'hFFFF_FFFF;
          3: lo = 32'h7FFF_FFFF;
          default: lo = 32'h8000_0000;
        endcase
      end
      6: lo = prev[31:0];
      7: lo = $urandom_range(0, 8) - 4;
      default: ;
    endcase
    return {hi, lo};
  endfunction

  function logic [sas_pkg::ELEM_W-1:0] double_element(logic [sas_pkg::ELEM_W-1:0] prev);
    logic        sgn;
    logic [51:0] frac;
    sgn  = 1'($urandom_range(0, 1));
    frac = 52'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: return {sgn, 63'd0};
      1: return {sgn, 11'h7FF, 52'd0};
      2: return {sgn, 11'h7FF, frac | (52'd1 << $urandom_range(0, 51))};
      3: return {sgn, 11'd0, frac};
      4: return {sgn, 11'h7FE, {52{1'b1}}};
      5: return prev;
      6: return {sgn, 11'h3FF + 11'($urandom_range(0, 3)), frac & 52'hF_0000_0000_0003};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Load one random set of the given size; the last element carries the mark
  task load_set(int size);
    logic [sas_pkg::ELEM_W-1:0] bits;
    int                         i;
    bits = '0;
    for (i = 0; i < size; i++) begin
      bits = (book.kind == sas_pkg::KIND_DOUBLE) ? double_element(bits) : int_element(bits);
      send_element(bits, i == size - 1);
    end
  endtask

  function int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return $urandom_range(1, 4);
    end
    if (r < 85) begin
      return $urandom_range(5, 12);
    end
    return $urandom_range(13, CAP + 3);
  endfunction

  initial begin
    int phase;
    int ksel;
    int loaded;
    int size;
    logic k;

    book = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Integer keys: extremes, upper bits carried through, equal keys stay in order
    write_kind(sas_pkg::KIND_INT);
    send_element(64'h0000_0000_7FFF_FFFF, 1'b0);
    send_element(64'hFFFF_FFFF_8000_0000, 1'b0);
    send_element(64'h1234_5678_0000_0000, 1'b0);
    send_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_element(64'h0000_0000_0000_0000, 1'b1);
    // single-element set
    send_element(64'hDEAD_BEEF_0000_0001, 1'b1);
    drain_results();

    // Kind switched while a set is loading: the kind at the final element rules
    send_element(64'h3FF0_0000_0000_0002, 1'b0);
    send_element(64'hBFF0_0000_0000_0001, 1'b0);
    drain_results();
    write_kind(sas_pkg::KIND_DOUBLE);
    send_element(64'h4000_0000_FFFF_FFFF, 1'b1);
    drain_results();

    // Double keys: signed zeros, infinities, NaNs, subnormal, largest finite
    send_element(64'h8000_0000_0000_0000, 1'b0);
    send_element(64'h7FF0_0000_0000_0000, 1'b0);
    send_element(64'h0000_0000_0000_0000, 1'b0);
    send_element(64'hFFF0_0000_0000_0000, 1'b0);
    send_element(64'h7FF8_0000_0000_0000, 1'b0);
    send_element(64'h3FF0_0000_0000_0000, 1'b0);
    send_element(64'hC004_0000_0000_0000, 1'b0);
    send_element(64'h7FF0_0000_0000_0000, 1'b0);
    send_element(64'h0000_0000_0000_0001, 1'b0);
    send_element(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_element(64'hFFF0_0000_0000_0001, 1'b1);
    drain_results();

    // Random sets: three idle patterns, both key kinds in each
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin idle_pct = 25; stall_pct = 80; end
        1: begin idle_pct = 80; stall_pct = 25; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (ksel = 0; ksel < 2; ksel++) begin
        k = (phase == 1) ? logic'(1 - ksel) : logic'(ksel);
        drain_results();
        write_kind(k);
        loaded = 0;
        // open with a set one past capacity, so the final element is dropped
        size = CAP + 1;
        while (loaded < PHASE_LEN) begin
          load_set(size);
          loaded += size;
          size = pick_size();
        end
      end
    end

    drain_results();
    $display("covered %0d sets, %0d elements in, %0d results out", book.sets_done,
             book.elements_seen, book.results_seen);
    $display("both key kinds, capacity overflow, and three sender/receiver idle patterns");
    if (book.mismatches == 0) begin
      $display("tb_stable_ascending_sorter: clean");
    end else begin
      $display("tb_stable_ascending_sorter: errors");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("tb_stable_ascending_sorter: errors");
    $finish;
  end

endmodule
